>>> sv/stpg_pkg.sv
// Shared types, constants and lookup tables of the stereo test pattern generator.
`default_nettype none

package stpg_pkg;

    localparam int COORD_W   = 13;
    localparam int DIV_STEPS = 8;
    localparam int REM_W     = 23;
    localparam int DEN_W     = 14;
    localparam int NDIV      = 4;

    // Divider lanes.
    localparam int DIV_R   = 0;
    localparam int DIV_G   = 1;
    localparam int DIV_B   = 2;
    localparam int DIV_BAR = 3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LAYOUT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_VTOTAL = 2'd3;

    typedef enum logic [1:0] {
        MODE_SBS   = 2'd0,
        MODE_TAB   = 2'd1,
        MODE_FPACK = 2'd2,
        MODE_DEEP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TIER_SMALL  = 2'd0,
        TIER_MEDIUM = 2'd1,
        TIER_LARGE  = 2'd2
    } t_tier;

    typedef struct packed {
        logic               deep;
        logic               deep_ok;
        logic               reg_bars;
        logic               reg_steps;
        logic               chk;
        logic               eye_ok;
        logic               eye;
        t_tier              tier;
        logic signed [5:0]  drift;
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] ly;
        logic [23:0]        color;
    } t_meta;

    localparam logic [23:0] CHECK_GREY = 24'h202020;

    function automatic logic [23:0] box_color(input logic [1:0] b);
        case (b)
            2'd0:    return 24'hc02020;
            2'd1:    return 24'h20c020;
            default: return 24'h2040c0;
        endcase
    endfunction

    function automatic logic [9:0] box_top(input t_tier t, input logic [1:0] b);
        logic [9:0] r;
        r = 10'd0;
        unique case (t)
            TIER_LARGE:  r = 10'd180 + 10'd240 * {8'd0, b};
            TIER_MEDIUM: r = 10'd40 + 10'd150 * {8'd0, b};
            default:     r = 10'd40 + 10'd115 * {8'd0, b};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] box_height(input t_tier t);
        logic [7:0] r;
        r = 8'd60;
        unique case (t)
            TIER_LARGE:  r = 8'd160;
            TIER_MEDIUM: r = 8'd100;
            default:     r = 8'd60;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] bar_color(input logic [2:0] i);
        case (i)
            3'd0:    return 24'hffffff;
            3'd1:    return 24'hffff00;
            3'd2:    return 24'h00ffff;
            3'd3:    return 24'h00ff00;
            3'd4:    return 24'hff00ff;
            3'd5:    return 24'hff0000;
            3'd6:    return 24'h0000ff;
            default: return 24'h000000;
        endcase
    endfunction

    function automatic logic [7:0] step_level(input logic [3:0] i);
        case (i)
            4'd0:    return 8'd0;
            4'd1:    return 8'd4;
            4'd2:    return 8'd8;
            4'd3:    return 8'd12;
            4'd4:    return 8'd16;
            4'd5:    return 8'd20;
            4'd6:    return 8'd24;
            4'd7:    return 8'd32;
            4'd8:    return 8'd219;
            4'd9:    return 8'd227;
            4'd10:   return 8'd231;
            4'd11:   return 8'd235;
            4'd12:   return 8'd239;
            4'd13:   return 8'd243;
            4'd14:   return 8'd251;
            default: return 8'd255;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> sv/stereo_test_pattern_pixel_gen.sv
// Top level of the stereo test pattern pixel generator with its configuration registers.
`default_nettype none

// Pixel generator for stereo and deep-colour test patterns. A pixel transfer is
// taken whenever i_start is high; o_busy is always low, so one pixel can be
// issued in every clock cycle. Each pixel's colour appears on o_pixel_color,
// marked by a one-cycle o_valid strobe, once it has passed the entry stage, the
// divider stages and the output register; pixels leave in the order they arrived.
// The pipeline length is set by the ramp dividers of the deep mode, which retire one
// quotient bit per pipeline stage over eight stages; the stereo layouts travel
// alongside in the same pipeline.
// The receiver cannot stall the block, so results must be taken as they come.
// The layout and size registers are written over the APB-style port and must
// only change while no pixel is in flight.
module stereo_test_pattern_pixel_gen
    import stpg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [11:0] i_pixel_x,
    input  wire logic [12:0] i_pixel_y,
    input  wire logic [6:0]  i_frame_count,
    output logic             o_valid,
    output logic [23:0]      o_pixel_color,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers.
    t_mode              r_mode;
    logic [COORD_W-1:0] r_w;
    logic [COORD_W-1:0] r_h;
    logic [COORD_W-1:0] r_vt;

    assign pready = 1'b1;
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SBS;
            r_w    <= 13'd1920;
            r_h    <= 13'd1080;
            r_vt   <= 13'd1125;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_LAYOUT: r_mode <= t_mode'(pwdata[1:0]);
                REG_WIDTH:  r_w    <= pwdata[COORD_W-1:0];
                REG_HEIGHT: r_h    <= pwdata[COORD_W-1:0];
                REG_VTOTAL: r_vt   <= pwdata[COORD_W-1:0];
                default:    r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LAYOUT: prdata = {30'd0, r_mode};
            REG_WIDTH:  prdata = {19'd0, r_w};
            REG_HEIGHT: prdata = {19'd0, r_h};
            REG_VTOTAL: prdata = {19'd0, r_vt};
            default:    prdata = 32'd0;
        endcase
    end

    // Divisors of the deep-mode ramps and of the bar and step index.
    logic [DEN_W-1:0] den [NDIV];
    always_comb begin
        den[DIV_R]   = {1'b0, r_w - 13'd1};
        den[DIV_G]   = {1'b0, r_h - 13'd1};
        den[DIV_B]   = {1'b0, r_w} + {1'b0, r_h} - 14'd2;
        den[DIV_BAR] = {1'b0, r_w};
    end

    // Pipeline registers: entry stage 0, then one divider step per stage.
    logic                   r_v    [DIV_STEPS+1];
    t_meta                  r_meta [DIV_STEPS+1];
    logic [REM_W-1:0]       r_rem  [DIV_STEPS+1][NDIV];
    logic [7:0]             r_q    [DIV_STEPS+1][NDIV];

    // Entry stage: locate the eye and build the ramp numerators.
    t_meta            n_meta;
    logic [REM_W-1:0] n_rem [NDIV];
    always_comb begin
        logic [COORD_W-1:0] x13;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] half;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] eh;
        logic [14:0]        h3;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] mid;
        logic [DEN_W-1:0]   xy;
        x13 = {1'b0, i_pixel_x};
        y   = i_pixel_y;
        eh  = r_h;
        dy  = y - r_vt;
        n_meta        = '0;
        n_meta.lx     = x13;
        n_meta.ly     = y;
        n_meta.drift  = $signed({1'b0, i_frame_count[6:2]}) - 6'sd16;
        unique case (r_mode)
            MODE_SBS: begin
                half = r_w >> 1;
                n_meta.eye_ok = (y < r_h) && (x13 < {half[11:0], 1'b0});
                n_meta.eye    = x13 >= half;
                if (x13 >= half) begin
                    n_meta.lx = x13 - half;
                end
            end
            MODE_TAB: begin
                half = r_h >> 1;
                eh   = half;
                n_meta.eye_ok = (x13 < r_w) && (y < {half[11:0], 1'b0});
                n_meta.eye    = y >= half;
                if (y >= half) begin
                    n_meta.ly = y - half;
                end
            end
            MODE_FPACK: begin
                half = '0;
                if (y >= r_vt && dy < r_h) begin
                    n_meta.eye_ok = x13 < r_w;
                    n_meta.eye    = 1'b1;
                    n_meta.ly     = dy;
                end else begin
                    n_meta.eye_ok = (x13 < r_w) && (y < r_h);
                end
            end
            default: begin
                half = '0;
                n_meta.deep = 1'b1;
            end
        endcase
        if (eh >= 13'd900) begin
            n_meta.tier = TIER_LARGE;
        end else if (eh >= 13'd500) begin
            n_meta.tier = TIER_MEDIUM;
        end else begin
            n_meta.tier = TIER_SMALL;
        end
        // Deep mode: bottom quarter split into bars and grey steps.
        h3  = ({2'b0, r_h} << 1) + {2'b0, r_h};
        top = h3[14:2];
        mid = top + ((r_h - top) >> 1);
        n_meta.deep_ok   = (x13 < r_w) && (y < r_h);
        n_meta.reg_bars  = (y >= top) && (y < mid);
        n_meta.reg_steps = y >= mid;
        n_meta.chk       = x13[6] ^ y[6];
        xy = {1'b0, x13} + {1'b0, y};
        n_rem[DIV_R]   = (REM_W'(x13) << 8) - REM_W'(x13);
        n_rem[DIV_G]   = (REM_W'(y) << 8) - REM_W'(y);
        n_rem[DIV_B]   = (REM_W'(xy) << 8) - REM_W'(xy);
        n_rem[DIV_BAR] = REM_W'(x13) << 4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta[0] <= n_meta;
        for (int d = 0; d < NDIV; d++) begin
            r_rem[0][d] <= n_rem[d];
            r_q[0][d]   <= 8'd0;
        end
    end

    // Eye colour: 40-pixel checker under three drifting boxes, later box wins.
    logic [23:0] eye_color;
    always_comb begin
        logic [19:0]        cx;
        logic [19:0]        cy;
        logic signed [10:0] bx;
        logic signed [10:0] off;
        logic [COORD_W-1:0] bxu;
        logic [COORD_W-1:0] byu;
        cx = {10'd0, r_meta[0].lx[12:3]} * 20'd205;
        cy = {10'd0, r_meta[0].ly[12:3]} * 20'd205;
        eye_color = (cx[10] ^ cy[10]) ? CHECK_GREY : 24'd0;
        for (int b = 0; b < 3; b++) begin
            off = 11'(11'sd16 * 11'(b - 1));
            if (r_meta[0].eye) begin
                off = -off;
            end
            bx  = 11'sd300 + 11'(r_meta[0].drift) + off;
            bxu = COORD_W'(bx);
            byu = COORD_W'(box_top(r_meta[0].tier, 2'(b)));
            if (r_meta[0].lx >= bxu && r_meta[0].lx < bxu + 13'd220 &&
                r_meta[0].ly >= byu &&
                r_meta[0].ly < byu + COORD_W'(box_height(r_meta[0].tier))) begin
                eye_color = box_color(2'(b));
            end
        end
        if (!r_meta[0].eye_ok) begin
            eye_color = 24'd0;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [REM_W-1:0] sd;
            t_meta            mt;
            // The eye colour joins the item as it leaves the entry stage.
            mt = r_meta[i-1];
            if (i == 1) begin
                mt.color = eye_color;
            end
            r_meta[i] <= mt;
            for (int d = 0; d < NDIV; d++) begin
                sd = REM_W'(den[d]) << (DIV_STEPS - i);
                if (r_rem[i-1][d] >= sd) begin
                    r_rem[i][d] <= r_rem[i-1][d] - sd;
                    r_q[i][d]   <= {r_q[i-1][d][6:0], 1'b1};
                end else begin
                    r_rem[i][d] <= r_rem[i-1][d];
                    r_q[i][d]   <= {r_q[i-1][d][6:0], 1'b0};
                end
            end
        end
    end

    // Final stage: pick the deep-mode colour or the eye colour.
    logic [23:0] n_color;
    always_comb begin
        t_meta       m;
        logic [7:0]  cr;
        logic [7:0]  cg;
        logic [8:0]  cb;
        logic [3:0]  qb;
        logic [7:0]  lv;
        m  = r_meta[DIV_STEPS];
        qb = r_q[DIV_STEPS][DIV_BAR][3:0];
        lv = step_level(qb);
        cr = (den[DIV_R] == '0) ? 8'd0 : r_q[DIV_STEPS][DIV_R];
        cg = (den[DIV_G] == '0) ? 8'd0 : r_q[DIV_STEPS][DIV_G];
        cb = (den[DIV_B] == '0) ? 9'd0 : {1'b0, r_q[DIV_STEPS][DIV_B]};
        if (m.chk) begin
            cb = cb + 9'd24;
            if (cb > 9'd255) begin
                cb = 9'd255;
            end
        end
        if (!m.deep) begin
            n_color = m.color;
        end else if (!m.deep_ok) begin
            n_color = 24'd0;
        end else if (m.reg_bars) begin
            n_color = bar_color(qb[3:1]);
        end else if (m.reg_steps) begin
            n_color = {lv, lv, lv};
        end else begin
            n_color = {cr, cg, cb[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid       <= 1'b0;
            o_pixel_color <= 24'd0;
        end else begin
            o_valid       <= r_v[DIV_STEPS];
            o_pixel_color <= r_v[DIV_STEPS] ? n_color : 24'd0;
        end
    end

`ifndef NO_ASSERTIONS
    // Every strobe traces back to an earlier transfer.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 10))
        else $error("result strobe without matching transfer");

    // Between strobes the colour bus rests at zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_pixel_color == 24'd0)
        else $error("colour bus not idle between results");

    // A transfer always yields a strobe once the pipeline has drained.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> ##9 o_valid)
        else $error("transfer lost in pipeline");
`endif

endmodule

`default_nettype wire

>>> verif/tb_stereo_test_pattern_pixel_gen.sv
// Self-checking testbench for the stereo test pattern pixel generator.
`timescale 1ns / 100ps

module tb_stereo_test_pattern_pixel_gen;
    import stpg_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [11:0] i_pixel_x;
    logic [12:0] i_pixel_y;
    logic [6:0]  i_frame_count;
    logic        o_valid;
    logic [23:0] o_pixel_color;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Pipeline depth of the block, in registers from i_start to o_valid.
    localparam int PIPE_DEPTH = 10;

    // Shadow copy of the configuration registers.
    t_mode       cfg_mode;
    logic [12:0] cfg_w;
    logic [12:0] cfg_h;
    logic [12:0] cfg_vt;

    // Colours still owed by the block, oldest first.
    logic [23:0] colour_queue[$];
    int          fail_count;
    int          sender_idle_pct;

    // One row of the directed table: registers, pixel, and an optional typed colour.
    typedef struct {
        t_mode       mode;
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] vt;
        logic [11:0] x;
        logic [12:0] y;
        logic [6:0]  fc;
        bit          typed;
        logic [23:0] colour;
    } t_row;

    stereo_test_pattern_pixel_gen u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_frame_count (i_frame_count),
        .o_valid       (o_valid),
        .o_pixel_color (o_pixel_color),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // The run is cut short here should the block stop answering.
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Ramp component: num * 255 / den, zero where the divisor is zero.
    function automatic logic [7:0] ramp_level(input int unsigned num, input int unsigned den);
        if (den == 0) return 8'd0;
        return 8'((num * 255) / den);
    endfunction

    // Colour of the deep ramp probe at (x, y) for a W by H frame.
    function automatic logic [23:0] deep_colour(input int unsigned x, input int unsigned y,
                                                input int unsigned w, input int unsigned h);
        int unsigned top, mid, v;
        logic [7:0]  r, g, b;
        logic [7:0]  lo_steps[8];
        logic [7:0]  hi_steps[8];
        logic [23:0] bars[8];
        lo_steps = '{0, 4, 8, 12, 16, 20, 24, 32};
        hi_steps = '{219, 227, 231, 235, 239, 243, 251, 255};
        bars = '{24'hffffff, 24'hffff00, 24'h00ffff, 24'h00ff00,
                 24'hff00ff, 24'hff0000, 24'h0000ff, 24'h000000};
        if (x >= w || y >= h) return 24'h0;
        top = h * 3 / 4;
        mid = top + (h - top) / 2;
        if (y >= top) begin
            if (y < mid) return bars[(x * 8 / w) & 7];
            v = x * 16 / w;
            r = (v < 8) ? lo_steps[v & 7] : hi_steps[(v - 8) & 7];
            return {r, r, r};
        end
        r = ramp_level(x, w - 1);
        g = ramp_level(y, h - 1);
        b = ramp_level(x + y, w + h - 2);
        // The 64-pixel checker lifts blue, saturating at full scale.
        if ((((x / 64) ^ (y / 64)) & 1) != 0) b = (b + 24 > 255) ? 8'd255 : b + 8'd24;
        return {r, g, b};
    endfunction

    // Colour of one eye: grey checker with three drifting boxes, later box on top.
    function automatic logic [23:0] eye_colour(input int unsigned x, input int unsigned y,
                                               input int unsigned eye_h, input bit right_eye,
                                               input int drift);
        logic [23:0] c;
        int          sh, bx, by, bh;
        logic [23:0] tints[3];
        tints = '{24'hc02020, 24'h20c020, 24'h2040c0};
        c = (((x / 40 + y / 40) & 1) != 0) ? 24'h202020 : 24'h0;
        for (int b = 0; b < 3; b++) begin
            sh = drift + (right_eye ? -1 : 1) * ((b - 1) * 16);
            bx = 300 + sh;
            if (eye_h >= 900) begin
                by = 180 + b * 240; bh = 160;
            end else if (eye_h >= 500) begin
                by = 40 + b * 150;  bh = 100;
            end else begin
                by = 40 + b * 115;  bh = 60;
            end
            if (int'(x) >= bx && int'(x) < bx + 220 && int'(y) >= by && int'(y) < by + bh)
                c = tints[b];
        end
        return c;
    endfunction

    // Expected colour of one pixel under the current register settings.
    function automatic logic [23:0] pixel_colour(input logic [11:0] px, input logic [12:0] py,
                                                 input logic [6:0] fc);
        int unsigned x, y, w, h, vt, half;
        int          drift;
        x = px; y = py; w = cfg_w; h = cfg_h; vt = cfg_vt;
        drift = int'((fc >> 2) & 31) - 16;
        case (cfg_mode)
            MODE_DEEP: return deep_colour(x, y, w, h);
            MODE_SBS: begin
                half = w / 2;
                if (y < h && x < 2 * half)
                    return (x < half) ? eye_colour(x, y, h, 1'b0, drift)
                                      : eye_colour(x - half, y, h, 1'b1, drift);
            end
            MODE_TAB: begin
                half = h / 2;
                if (x < w && y < 2 * half)
                    return (y < half) ? eye_colour(x, y, half, 1'b0, drift)
                                      : eye_colour(x, y - half, half, 1'b1, drift);
            end
            default: begin
                // Frame packing: the second eye wins where it overlaps the first.
                if (x < w) begin
                    if (y >= vt && y - vt < h) return eye_colour(x, y - vt, h, 1'b1, drift);
                    if (y < h) return eye_colour(x, y, h, 1'b0, drift);
                end
            end
        endcase
        return 24'h0;
    endfunction

    // One APB write: setup cycle, then access cycle completing on pready.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {19'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LAYOUT: cfg_mode = t_mode'(value[1:0]);
            REG_WIDTH:  cfg_w = value;
            REG_HEIGHT: cfg_h = value;
            default:    cfg_vt = value;
        endcase
    endtask

    // Stops issuing, then lets every owed colour arrive, plus the pipeline depth.
    task automatic drain;
        int guard;
        guard = 0;
        i_start <= 1'b0;
        while (colour_queue.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic set_layout(input t_mode m, input logic [12:0] w, input logic [12:0] h,
                              input logic [12:0] vt);
        drain();
        write_reg(REG_LAYOUT, 13'(m));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_VTOTAL, vt);
    endtask

    // Issues one pixel transfer, idling beforehand at the chosen rate.
    // i_start is left high so that transfers can follow back to back; the idle
    // loop and drain() lower it.
    task automatic send_pixel(input logic [11:0] x, input logic [12:0] y, input logic [6:0] fc,
                              input bit typed, input logic [23:0] colour);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_pixel_x     <= x;
        i_pixel_y     <= y;
        i_frame_count <= fc;
        do @(posedge i_clk); while (o_busy);
        colour_queue.push_back(typed ? colour : pixel_colour(x, y, fc));
    endtask

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (colour_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected colour %06h", o_pixel_color));
            end else begin
                if (o_pixel_color !== colour_queue[0])
                    report_mismatch($sformatf("colour %06h, expected %06h",
                                              o_pixel_color, colour_queue[0]));
                void'(colour_queue.pop_front());
            end
        end
    end

    // Random pixel biased towards the active region and its borders.
    task automatic random_pixel;
        logic [11:0] x;
        logic [12:0] y;
        int unsigned span;
        span = (cfg_mode == MODE_FPACK) ? cfg_h + cfg_vt : cfg_h;
        case ($urandom_range(9))
            0:       x = 12'($urandom);
            1:       x = 12'(cfg_w - 12'($urandom_range(2)));
            default: x = 12'($urandom_range(cfg_w > 0 ? cfg_w - 1 : 0));
        endcase
        case ($urandom_range(9))
            0:       y = 13'($urandom);
            1:       y = 13'(span - $urandom_range(2));
            default: y = 13'($urandom_range(span > 0 ? span - 1 : 0));
        endcase
        send_pixel(x, y, 7'($urandom), 1'b0, 24'h0);
    endtask

    initial begin
        t_row rows[$];
        t_mode m;
        logic [12:0] rw, rh, rvt;
        fail_count      = 0;
        sender_idle_pct = 0;
        cfg_mode = MODE_SBS; cfg_w = 13'd1920; cfg_h = 13'd1080; cfg_vt = 13'd1125;
        i_rst_n = 1'b0; i_start = 1'b0;
        i_pixel_x = '0; i_pixel_y = '0; i_frame_count = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; colours typed where they are plain to see.
        rows = '{
            '{MODE_SBS, 1920, 1080, 1125, 0, 0, 0, 1, 24'h0},
            '{MODE_SBS, 1920, 1080, 1125, 40, 0, 0, 1, 24'h202020},
            '{MODE_SBS, 1920, 1080, 1125, 4095, 0, 0, 1, 24'h0},
            '{MODE_SBS, 1920, 1080, 1125, 0, 8191, 127, 1, 24'h0},
            '{MODE_SBS, 1920, 1080, 1125, 400, 200, 64, 0, 0},
            '{MODE_SBS, 1920, 1080, 1125, 1360, 500, 127, 0, 0},
            '{MODE_SBS, 1921, 1080, 1125, 1920, 10, 0, 1, 24'h0},
            '{MODE_TAB, 1920, 1081, 1125, 10, 1080, 0, 1, 24'h0},
            '{MODE_TAB, 1920, 1080, 1125, 400, 100, 3, 0, 0},
            '{MODE_TAB, 1920, 1080, 1125, 330, 660, 90, 0, 0},
            '{MODE_FPACK, 1920, 1080, 1125, 10, 1100, 0, 1, 24'h0},
            '{MODE_FPACK, 1920, 1080, 1125, 400, 1400, 50, 0, 0},
            '{MODE_FPACK, 1920, 1080, 1125, 10, 2205, 0, 1, 24'h0},
            '{MODE_FPACK, 1920, 1080, 600, 400, 700, 20, 0, 0},
            '{MODE_FPACK, 4096, 4096, 8191, 4095, 8191, 127, 0, 0},
            '{MODE_FPACK, 2, 2, 2, 1, 3, 0, 0, 0},
            '{MODE_DEEP, 1920, 1080, 1125, 0, 0, 0, 1, 24'h000000},
            '{MODE_DEEP, 1920, 1080, 1125, 1919, 0, 0, 0, 0},
            '{MODE_DEEP, 1920, 1080, 1125, 70, 30, 0, 0, 0},
            '{MODE_DEEP, 1920, 1080, 1125, 0, 850, 0, 1, 24'hffffff},
            '{MODE_DEEP, 1920, 1080, 1125, 1919, 1079, 0, 1, 24'hffffff},
            '{MODE_DEEP, 1920, 1080, 1125, 0, 1079, 0, 1, 24'h000000},
            '{MODE_DEEP, 1, 1, 1125, 0, 0, 0, 1, 24'h0},
            '{MODE_DEEP, 1, 1080, 1125, 0, 500, 0, 0, 0},
            '{MODE_DEEP, 4096, 4096, 1125, 4095, 3000, 0, 0, 0}
        };
        foreach (rows[i]) begin
            if (rows[i].mode != cfg_mode || rows[i].w != cfg_w || rows[i].h != cfg_h ||
                rows[i].vt != cfg_vt)
                set_layout(rows[i].mode, rows[i].w, rows[i].h, rows[i].vt);
            send_pixel(rows[i].x, rows[i].y, rows[i].fc, rows[i].typed, rows[i].colour);
        end

        // Random phases: each picks new register settings, sometimes extreme.
        for (int phase = 0; phase < 25; phase++) begin
            sender_idle_pct = (phase < 8) ? 20 : (phase < 16) ? 76 : 0;
            m = t_mode'($urandom_range(3));
            case ($urandom_range(4))
                0: begin rw = 13'd4096; rh = 13'd4096; rvt = 13'd8191; end
                1: begin rw = 13'd2; rh = 13'd2; rvt = 13'd2; end
                default: begin
                    rw  = 13'($urandom_range(2, 4096));
                    rh  = 13'($urandom_range(2, 4096));
                    rvt = 13'($urandom_range(2, 8191 - rh));
                end
            endcase
            set_layout(m, rw, rh, rvt);
            for (int n = 0; n < 50; n++) random_pixel();
            // Once, hold off until the pipe has emptied mid-phase.
            if (phase == 3) begin
                drain();
                for (int n = 0; n < 10; n++) random_pixel();
            end
        end

        drain();
        if (fail_count == 0 && colour_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
sv/stpg_pkg.sv
sv/stereo_test_pattern_pixel_gen.sv
verif/tb_stereo_test_pattern_pixel_gen.sv
